// ----- hw/rtl/buffer_slot_allocator_core_defines.svh -----
// Assertion macros shared by the buffer slot allocator RTL
`ifndef BUFFER_SLOT_ALLOCATOR_CORE_DEFINES_SVH
`define BUFFER_SLOT_ALLOCATOR_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Antecedent implies consequent in the same cycle
`define BSA_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bsa check failed");

// Antecedent implies consequent in the next cycle
`define BSA_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bsa check failed");

`else

`define BSA_ASSERT_IMP(lbl, ante, cons)
`define BSA_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// ----- hw/rtl/bsa_pkg.sv -----
// Types and constants for the buffer slot allocator
package bsa_pkg;

	localparam int unsigned SLOT_OUT_W = 5;
	localparam logic [31:0] VERSION_VALUE = 32'd1;
	localparam logic [31:0] FEATURES_VALUE = 32'd0;

	typedef enum logic [2:0] {
		MD_VERSION  = 3'd0,
		MD_FEATURES = 3'd1,
		MD_NEW      = 3'd2,
		MD_DISPOSE  = 3'd3,
		MD_GET_SIZE = 3'd4,
		MD_XFER     = 3'd5
	} mode_t;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_NO_SLOT    = 3'd1,
		ST_SLOT_FREE  = 3'd2,
		ST_NONE_FREE  = 3'd3,
		ST_BEYOND_END = 3'd4,
		ST_UNKNOWN    = 3'd5
	} status_t;

endpackage

// ----- hw/rtl/bsa_first_free.sv -----
// Lowest-free-slot priority encoder over the allocated mask
module bsa_first_free import bsa_pkg::*; #(
	parameter int unsigned N = 32,
	parameter int unsigned IDX_W = 5
) (
	input  logic [N-1:0]     used,
	output logic             found,
	output logic [IDX_W-1:0] idx,
	output logic [N-1:0]     onehot
);

	logic [N-1:0] free_bits;

	// Isolate the lowest set bit of the free mask
	assign free_bits = ~used;
	assign onehot = free_bits & (~free_bits + N'(1));
	assign found = |free_bits;

	// Encode the one-hot grant into an index
	always_comb begin
		idx = '0;
		for (int unsigned i = 0; i < N; i++) begin
			if (onehot[i]) begin
				idx = idx | IDX_W'(i);
			end
		end
	end

endmodule

// ----- hw/rtl/buffer_slot_allocator_core.sv -----
// Top level of the buffer slot allocator: command decode, slot state, result register
//
// Channel | Direction | Handshake          | Beat contents
// in      | input     | in_valid/in_ready  | mode, slot, byte_count, byte_offset
// out     | output    | out_valid/out_ready| status, slot_out, value
//
// One beat is accepted per cycle while in_ready is high; each result becomes valid once its
// command has passed the input register and then the result register, which it enters when
// that register is free or drained, through the combinational decode, priority encode and size table access.
// Reset clears the allocated mask (every slot free); the size table is not cleared.
// With out_ready low the result holds, the input register takes one more beat,
// then in_ready drops until the result is taken.
`include "buffer_slot_allocator_core_defines.svh"

module buffer_slot_allocator_core import bsa_pkg::*; #(
	parameter int unsigned NUM_SLOTS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [2:0]            mode,
	input  logic [15:0]           slot,
	input  logic [31:0]           byte_count,
	input  logic [31:0]           byte_offset,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [2:0]            status,
	output logic [SLOT_OUT_W-1:0] slot_out,
	output logic [31:0]           value
);

	localparam int unsigned IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

	// Input register
	logic        valid_s1;
	logic [2:0]  mode_s1;
	logic [15:0] slot_s1;
	logic [31:0] count_s1;
	logic [31:0] offset_s1;

	// Slot state
	logic [NUM_SLOTS-1:0] alloc_q;
	logic [NUM_SLOTS-1:0] alloc_d;
	logic [31:0]          sizes_q [NUM_SLOTS];

	// Result register
	logic                  out_valid_q;
	status_t               status_q;
	logic [SLOT_OUT_W-1:0] slot_out_q;
	logic [31:0]           value_q;

	// Decode
	logic                  advance;
	logic                  in_range;
	logic                  in_use;
	logic [IDX_W-1:0]      slot_idx;
	logic [31:0]           size_rd;
	status_t               check_st;
	logic [32:0]           xfer_end;
	logic                  free_found;
	logic [IDX_W-1:0]      free_idx;
	logic [NUM_SLOTS-1:0]  free_onehot;
	logic                  size_wr;
	status_t               status_d;
	logic [SLOT_OUT_W-1:0] slot_out_d;
	logic [31:0]           value_d;

	// Advance the input stage when the result register is free or being drained
	assign advance = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Capture the input beat
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			mode_s1 <= mode;
			slot_s1 <= slot;
			count_s1 <= byte_count;
			offset_s1 <= byte_offset;
		end
	end

	bsa_first_free #(
		.N     (NUM_SLOTS),
		.IDX_W (IDX_W)
	) u_first_free (
		.used   (alloc_q),
		.found  (free_found),
		.idx    (free_idx),
		.onehot (free_onehot)
	);

	// Check the named slot and read its size
	assign in_range = slot_s1 < 16'(NUM_SLOTS);
	assign slot_idx = slot_s1[IDX_W-1:0];
	assign in_use = in_range && alloc_q[slot_idx];
	assign size_rd = in_range ? sizes_q[slot_idx] : 32'd0;
	assign xfer_end = {1'b0, offset_s1} + {1'b0, count_s1};

	always_comb begin
		if (!in_range) begin
			check_st = ST_NO_SLOT;
		end else if (!in_use) begin
			check_st = ST_SLOT_FREE;
		end else begin
			check_st = ST_OK;
		end
	end

	// Decode the command into a result and the next mask
	always_comb begin
		status_d = ST_OK;
		slot_out_d = '0;
		value_d = '0;
		alloc_d = alloc_q;
		size_wr = 1'b0;
		case (mode_s1)
			MD_VERSION: begin
				value_d = VERSION_VALUE;
			end
			MD_FEATURES: begin
				value_d = FEATURES_VALUE;
			end
			MD_NEW: begin
				if (free_found) begin
					slot_out_d = SLOT_OUT_W'(free_idx);
					alloc_d = alloc_q | free_onehot;
					size_wr = 1'b1;
				end else begin
					status_d = ST_NONE_FREE;
				end
			end
			MD_DISPOSE: begin
				status_d = check_st;
				if (check_st == ST_OK) begin
					alloc_d[slot_idx] = 1'b0;
				end
			end
			MD_GET_SIZE: begin
				status_d = check_st;
				if (check_st == ST_OK) begin
					value_d = size_rd;
				end
			end
			MD_XFER: begin
				status_d = check_st;
				if (check_st == ST_OK && xfer_end > {1'b0, size_rd}) begin
					status_d = ST_BEYOND_END;
				end
			end
			default: begin
				status_d = ST_UNKNOWN;
			end
		endcase
	end

	// Update the allocated mask
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alloc_q <= '0;
		end else if (advance) begin
			alloc_q <= alloc_d;
		end
	end

	// Record the size of a newly granted slot
	always_ff @(posedge clk) begin
		if (advance && size_wr) begin
			sizes_q[free_idx] <= count_s1;
		end
	end

	// Hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			status_q <= status_d;
			slot_out_q <= slot_out_d;
			value_q <= value_d;
		end
	end

	assign out_valid = out_valid_q;
	assign status = status_q;
	assign slot_out = slot_out_q;
	assign value = value_q;

	// A grant marks its slot allocated
	`BSA_ASSERT_NXT(a_new_sets_bit, advance && size_wr, alloc_q[$past(free_idx)])
	// A good dispose leaves its slot free
	`BSA_ASSERT_NXT(a_dispose_clears, advance && mode_s1 == MD_DISPOSE && status_d == ST_OK, !alloc_q[$past(slot_idx)])
	// None free is reported only with a full mask
	`BSA_ASSERT_IMP(a_none_free_full, advance && status_d == ST_NONE_FREE, &alloc_q)

endmodule
